// ===== rtl/core/timed_color_fade_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the fade block
// Each macro samples on the rising edge of clk and is quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TIMED_COLOR_FADE_MACROS_SVH
`define TIMED_COLOR_FADE_MACROS_SVH

// Property that must hold at every sampled edge.
`define TCF_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("fade block invariant violated");

// Property whose consequent must hold in the cycle after the antecedent.
`define TCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fade block sequence violated");

`endif

// ===== rtl/core/tcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcf_pkg
// Types and constants shared by the timed color fade pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tcf_pkg;

  localparam int unsigned CHANNEL_BITS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF    = 32;

  // Fade fraction is unsigned Q1.16
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned FRAC_W    = FRAC_BITS + 1;
  localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    MODE_NONE   = 3'd0,
    MODE_IN     = 3'd1,
    MODE_OUT    = 3'd2,
    MODE_SQ_IN  = 3'd3,
    MODE_SQ_OUT = 3'd4
  } fade_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FADE_MODE = 2'd0,
    REG_WIN_START = 2'd1,
    REG_WIN_END   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FS_ZERO = 2'd0,
    FS_ONE  = 2'd1,
    FS_DIV  = 2'd2
  } frac_sel_t;

  typedef struct packed {
    frac_sel_t sel;
    logic      invert;
    logic      squared;
  } fade_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcf_if.sv =====
// ----------------------------------------------------------------------------
// tcf stream interfaces
// Valid/ready channels for the pixel-plus-time input and the faded pixel output.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcf_pix_if
  import tcf_pkg::*;
#(
  parameter int unsigned CW = CHANNEL_BITS_DEF,
  parameter int unsigned TW = TIME_BITS_DEF
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] red_in;
  logic [CW-1:0] green_in;
  logic [CW-1:0] blue_in;
  logic [TW-1:0] now_ms;

  modport source (output valid, red_in, green_in, blue_in, now_ms, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, now_ms, output ready);
endinterface

interface tcf_rgb_if
  import tcf_pkg::*;
#(
  parameter int unsigned CW = CHANNEL_BITS_DEF
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] red_out;
  logic [CW-1:0] green_out;
  logic [CW-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tcf_window.sv =====
// ----------------------------------------------------------------------------
// tcf_window
// Entry stage: decode mode, place the time against the window, form divider inputs.
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_window
  import tcf_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int unsigned TIME_BITS    = TIME_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [2:0]                mode_i,
  input  wire logic [TIME_BITS-1:0]      win_start_i,
  input  wire logic [TIME_BITS-1:0]      win_end_i,
  input  wire logic                      valid_i,
  output      logic                      ready_o,
  input  wire logic [3*CHANNEL_BITS-1:0] pix_i,
  input  wire logic [TIME_BITS-1:0]      now_i,
  output      logic                      valid_o,
  input  wire logic                      ready_i,
  output      logic [3*CHANNEL_BITS-1:0] pix_o,
  output      fade_ctl_t                 ctl_o,
  output      logic [TIME_BITS-1:0]      num_o,
  output      logic [TIME_BITS-1:0]      den_o
);

  logic                      valid_r;
  logic [3*CHANNEL_BITS-1:0] pix_r;
  fade_ctl_t                 ctl_r, ctl_nxt;
  logic [TIME_BITS-1:0]      num_r, den_r;
  logic                      active, fade_in, squared;
  logic                      before_win, after_win;

  always_comb begin
    active  = 1'b1;
    fade_in = 1'b1;
    squared = 1'b0;
    unique case (mode_i)
      MODE_IN:     begin fade_in = 1'b1; squared = 1'b0; end
      MODE_OUT:    begin fade_in = 1'b0; squared = 1'b0; end
      MODE_SQ_IN:  begin fade_in = 1'b1; squared = 1'b1; end
      MODE_SQ_OUT: begin fade_in = 1'b0; squared = 1'b1; end
      default:     active = 1'b0;
    endcase
  end

  assign before_win = now_i < win_start_i;
  assign after_win  = now_i >= win_end_i;

  always_comb begin
    ctl_nxt.invert  = ~fade_in;
    ctl_nxt.squared = squared;
    priority if (!active) begin
      ctl_nxt.sel = FS_ONE;
    end else if (before_win) begin
      ctl_nxt.sel = fade_in ? FS_ZERO : FS_ONE;
    end else if (after_win) begin
      ctl_nxt.sel = fade_in ? FS_ONE : FS_ZERO;
    end else begin
      ctl_nxt.sel = FS_DIV;
    end
  end

  assign ready_o = ~valid_r | ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      pix_r <= pix_i;
      ctl_r <= ctl_nxt;
      num_r <= now_i - win_start_i;
      den_r <= win_end_i - win_start_i;
    end
  end

  assign valid_o = valid_r;
  assign pix_o   = pix_r;
  assign ctl_o   = ctl_r;
  assign num_o   = num_r;
  assign den_o   = den_r;

endmodule

`default_nettype wire

// ===== rtl/core/tcf_div_step.sv =====
// ----------------------------------------------------------------------------
// tcf_div_step
// One registered quotient bit of the fraction divider, num * 2^16 / den.
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_div_step
  import tcf_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int unsigned TIME_BITS    = TIME_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      valid_i,
  output      logic                      ready_o,
  input  wire logic [3*CHANNEL_BITS-1:0] pix_i,
  input  wire fade_ctl_t                 ctl_i,
  input  wire logic [TIME_BITS-1:0]      rem_i,
  input  wire logic [TIME_BITS-1:0]      den_i,
  input  wire logic [FRAC_BITS-1:0]      quo_i,
  output      logic                      valid_o,
  input  wire logic                      ready_i,
  output      logic [3*CHANNEL_BITS-1:0] pix_o,
  output      fade_ctl_t                 ctl_o,
  output      logic [TIME_BITS-1:0]      rem_o,
  output      logic [TIME_BITS-1:0]      den_o,
  output      logic [FRAC_BITS-1:0]      quo_o
);

  logic                      valid_r;
  logic [3*CHANNEL_BITS-1:0] pix_r;
  fade_ctl_t                 ctl_r;
  logic [TIME_BITS-1:0]      rem_r, den_r, rem_nxt, gap;
  logic [FRAC_BITS-1:0]      quo_r;
  logic                      take;

  // Compare against den - rem so 2*rem never has to be formed when it would overflow
  assign gap     = den_i - rem_i;
  assign take    = rem_i >= gap;
  assign rem_nxt = take ? (rem_i - gap) : {rem_i[TIME_BITS-2:0], 1'b0};

  assign ready_o = ~valid_r | ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      pix_r <= pix_i;
      ctl_r <= ctl_i;
      rem_r <= rem_nxt;
      den_r <= den_i;
      quo_r <= {quo_i[FRAC_BITS-2:0], take};
    end
  end

  assign valid_o = valid_r;
  assign pix_o   = pix_r;
  assign ctl_o   = ctl_r;
  assign rem_o   = rem_r;
  assign den_o   = den_r;
  assign quo_o   = quo_r;

endmodule

`default_nettype wire

// ===== rtl/core/tcf_shape.sv =====
// ----------------------------------------------------------------------------
// tcf_shape
// Pick the fraction, apply fade-out complement, and form its square.
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_shape
  import tcf_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      valid_i,
  output      logic                      ready_o,
  input  wire logic [3*CHANNEL_BITS-1:0] pix_i,
  input  wire fade_ctl_t                 ctl_i,
  input  wire logic [FRAC_BITS-1:0]      quo_i,
  output      logic                      valid_o,
  input  wire logic                      ready_i,
  output      logic [3*CHANNEL_BITS-1:0] pix_o,
  output      logic                      squared_o,
  output      logic [FRAC_W-1:0]         frac_o,
  output      logic [2*FRAC_W-1:0]       frac_sq_o
);

  logic                      valid_r;
  logic [3*CHANNEL_BITS-1:0] pix_r;
  logic                      squared_r;
  logic [FRAC_W-1:0]         frac_r, frac_nxt, quo_ext;
  logic [2*FRAC_W-1:0]       frac_sq_r;

  assign quo_ext = {1'b0, quo_i};

  always_comb begin
    unique case (ctl_i.sel)
      FS_ZERO: frac_nxt = '0;
      FS_ONE:  frac_nxt = FRAC_ONE;
      FS_DIV:  frac_nxt = ctl_i.invert ? (FRAC_ONE - quo_ext) : quo_ext;
      default: frac_nxt = '0;
    endcase
  end

  assign ready_o = ~valid_r | ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      pix_r     <= pix_i;
      squared_r <= ctl_i.squared;
      frac_r    <= frac_nxt;
      frac_sq_r <= frac_nxt * frac_nxt;
    end
  end

  assign valid_o   = valid_r;
  assign pix_o     = pix_r;
  assign squared_o = squared_r;
  assign frac_o    = frac_r;
  assign frac_sq_o = frac_sq_r;

endmodule

`default_nettype wire

// ===== rtl/core/tcf_scale.sv =====
// ----------------------------------------------------------------------------
// tcf_scale
// Output stage: scale each channel by the final fraction and hold the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_scale
  import tcf_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      valid_i,
  output      logic                      ready_o,
  input  wire logic [3*CHANNEL_BITS-1:0] pix_i,
  input  wire logic                      squared_i,
  input  wire logic [FRAC_W-1:0]         frac_i,
  input  wire logic [2*FRAC_W-1:0]       frac_sq_i,
  output      logic                      valid_o,
  input  wire logic                      ready_i,
  output      logic [3*CHANNEL_BITS-1:0] pix_o
);

  localparam int unsigned PW = CHANNEL_BITS + FRAC_W;

  logic                      valid_r;
  logic [3*CHANNEL_BITS-1:0] pix_r, pix_nxt;
  logic [FRAC_W-1:0]         frac;
  logic [PW-1:0]             prod [3];

  assign frac = squared_i ? frac_sq_i[FRAC_BITS +: FRAC_W] : frac_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = PW'(pix_i[k*CHANNEL_BITS +: CHANNEL_BITS]) * PW'(frac);
      pix_nxt[k*CHANNEL_BITS +: CHANNEL_BITS] = prod[k][FRAC_BITS +: CHANNEL_BITS];
    end
  end

  assign ready_o = ~valid_r | ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      pix_r <= pix_nxt;
    end
  end

  assign valid_o = valid_r;
  assign pix_o   = pix_r;

endmodule

`default_nettype wire

// ===== rtl/core/timed_color_fade.sv =====
// ----------------------------------------------------------------------------
// timed_color_fade
// Time-windowed linear or squared brightness fade of an RGB pixel stream.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Word contents
// in_pix    in   valid/ready        red_in, green_in, blue_in, now_ms
// out_rgb   out  valid/ready        red_out, green_out, blue_out
// cfg_*     in   write enable only  cfg_index selects mode, start or end
//
// One word enters per cycle while out_rgb is not stalled; the stages are:
// one window stage, one stage per quotient bit of the fraction divider, one
// shaping stage (complement and square) and one scaling stage that is the
// output register. Reset clears all stage valid bits and the registers
// (mode none, empty window). Each stage holds its word while the next one is
// full and stalled, so a stall on out_rgb backs up without loss.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timed_color_fade_macros.svh"

module timed_color_fade
  import tcf_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int unsigned TIME_BITS    = TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  tcf_pix_if.sink                   in_pix,
  tcf_rgb_if.source                 out_rgb,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TIME_BITS-1:0] cfg_wdata
);

  localparam int unsigned PIX_W = 3 * CHANNEL_BITS;

  // Configuration registers
  logic [2:0]           mode_r;
  logic [TIME_BITS-1:0] win_start_r;
  logic [TIME_BITS-1:0] win_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 3'(MODE_NONE);
      win_start_r <= '0;
      win_end_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FADE_MODE: mode_r      <= cfg_wdata[2:0];
        REG_WIN_START: win_start_r <= cfg_wdata;
        REG_WIN_END:   win_end_r   <= cfg_wdata;
        default:       ;  // unmapped index: drop the write
      endcase
    end
  end

  // Entry stage
  logic [PIX_W-1:0] in_pixel;
  assign in_pixel = {in_pix.red_in, in_pix.green_in, in_pix.blue_in};

  logic                 div_valid [FRAC_BITS+1];
  logic                 div_ready [FRAC_BITS+1];
  logic [PIX_W-1:0]     div_pix   [FRAC_BITS+1];
  fade_ctl_t            div_ctl   [FRAC_BITS+1];
  logic [TIME_BITS-1:0] div_rem   [FRAC_BITS+1];
  logic [TIME_BITS-1:0] div_den   [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] div_quo   [FRAC_BITS+1];

  tcf_window #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .TIME_BITS    (TIME_BITS)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .mode_i      (mode_r),
    .win_start_i (win_start_r),
    .win_end_i   (win_end_r),
    .valid_i     (in_pix.valid),
    .ready_o     (in_pix.ready),
    .pix_i       (in_pixel),
    .now_i       (in_pix.now_ms),
    .valid_o     (div_valid[0]),
    .ready_i     (div_ready[0]),
    .pix_o       (div_pix[0]),
    .ctl_o       (div_ctl[0]),
    .num_o       (div_rem[0]),
    .den_o       (div_den[0])
  );

  // Quotient starts empty; each step shifts in one bit
  assign div_quo[0] = '0;

  // Divider: one quotient bit per stage, most significant first
  for (genvar s = 0; s < FRAC_BITS; s++) begin : g_div
    tcf_div_step #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .TIME_BITS    (TIME_BITS)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (div_valid[s]),
      .ready_o (div_ready[s]),
      .pix_i   (div_pix[s]),
      .ctl_i   (div_ctl[s]),
      .rem_i   (div_rem[s]),
      .den_i   (div_den[s]),
      .quo_i   (div_quo[s]),
      .valid_o (div_valid[s+1]),
      .ready_i (div_ready[s+1]),
      .pix_o   (div_pix[s+1]),
      .ctl_o   (div_ctl[s+1]),
      .rem_o   (div_rem[s+1]),
      .den_o   (div_den[s+1]),
      .quo_o   (div_quo[s+1])
    );
  end

  // Shaping stage
  logic                   shp_valid, shp_ready;
  logic [PIX_W-1:0]       shp_pix;
  logic                   shp_squared;
  logic [FRAC_W-1:0]      shp_frac;
  logic [2*FRAC_W-1:0]    shp_frac_sq;

  tcf_shape #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_shape (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (div_valid[FRAC_BITS]),
    .ready_o   (div_ready[FRAC_BITS]),
    .pix_i     (div_pix[FRAC_BITS]),
    .ctl_i     (div_ctl[FRAC_BITS]),
    .quo_i     (div_quo[FRAC_BITS]),
    .valid_o   (shp_valid),
    .ready_i   (shp_ready),
    .pix_o     (shp_pix),
    .squared_o (shp_squared),
    .frac_o    (shp_frac),
    .frac_sq_o (shp_frac_sq)
  );

  // Scaling stage doubles as the output register
  logic [PIX_W-1:0] out_pixel;

  tcf_scale #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (shp_valid),
    .ready_o   (shp_ready),
    .pix_i     (shp_pix),
    .squared_i (shp_squared),
    .frac_i    (shp_frac),
    .frac_sq_i (shp_frac_sq),
    .valid_o   (out_rgb.valid),
    .ready_i   (out_rgb.ready),
    .pix_o     (out_pixel)
  );

  assign out_rgb.red_out   = out_pixel[2*CHANNEL_BITS +: CHANNEL_BITS];
  assign out_rgb.green_out = out_pixel[CHANNEL_BITS +: CHANNEL_BITS];
  assign out_rgb.blue_out  = out_pixel[0 +: CHANNEL_BITS];

  // Every stage occupied
  logic pipe_full;
  always_comb begin
    pipe_full = shp_valid & out_rgb.valid;
    for (int s = 0; s <= FRAC_BITS; s++) begin
      pipe_full = pipe_full & div_valid[s];
    end
  end

  // Last divider stage holds a word that took the division path
  logic div_in_win;
  assign div_in_win = div_valid[FRAC_BITS] && (div_ctl[FRAC_BITS].sel == FS_DIV);

  // Input backs up only when every stage holds a word
  `TCF_ASSERT_ALWAYS(a_ready_low_only_full, in_pix.ready || pipe_full)
  // Divider remainder stays below the divisor for words inside the window
  `TCF_ASSERT_ALWAYS(a_rem_below_den, !div_in_win || (div_rem[FRAC_BITS] < div_den[FRAC_BITS]))
  // Shaped fraction never exceeds 1.0
  `TCF_ASSERT_ALWAYS(a_frac_le_one, !shp_valid || (shp_frac <= FRAC_ONE))
  // A full pipe facing a stalled sink keeps every word
  `TCF_ASSERT_NEXT(a_full_holds, pipe_full && !out_rgb.ready, pipe_full)

endmodule

`default_nettype wire

// ===== test/timed_color_fade_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timed_color_fade_test
// Self-checking bench for the windowed fade block. Pixel words stream in on
// one valid/ready channel and faded words come back on the other. A
// scoreboard predicts each faded word from its own copy of the fade
// registers. Short directed checks cover the window edges and every mode,
// then random windows and modes run under random gaps, long output stalls
// and idle register rewrites.
// ----------------------------------------------------------------------------

module timed_color_fade_test;
  import tcf_pkg::*;

  localparam int unsigned CW = CHANNEL_BITS_DEF;
  localparam int unsigned TW = TIME_BITS_DEF;

  // Window stage, one stage per quotient bit, shaping stage, scaling stage.
  localparam int unsigned PIPE_LATENCY   = FRAC_BITS + 3;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES  = 20;
  localparam int unsigned PHASE_ITEMS    = 85;
  localparam int unsigned MAX_REPORTS    = 10;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
  } rgb_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the fade registers, predicts each faded word when the
  // pixel word is accepted and checks returning words in order.
  // --------------------------------------------------------------------------
  class fade_scoreboard;
    logic [2:0]    mode;
    logic [TW-1:0] win_start;
    logic [TW-1:0] win_end;
    rgb_word_t     expected_rgb[$];
    int unsigned   mismatches;
    int unsigned   results_seen;

    function new();
      mode         = MODE_NONE;
      win_start    = '0;
      win_end      = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TW-1:0] value);
      case (idx)
        REG_FADE_MODE: mode      = value[2:0];
        REG_WIN_START: win_start = value;
        REG_WIN_END:   win_end   = value;
        default: ;
      endcase
    endfunction

    // Q1.16 fraction for one timestamp under the current mode and window.
    function logic [FRAC_W-1:0] fade_fraction(logic [TW-1:0] t);
      logic          fade_in;
      logic          squared;
      logic [TW-1:0] offs;
      logic [TW-1:0] span;
      logic [63:0]   num;
      logic [63:0]   f;
      fade_in = (mode == MODE_IN) || (mode == MODE_SQ_IN);
      squared = (mode == MODE_SQ_IN) || (mode == MODE_SQ_OUT);
      if (mode == MODE_NONE || mode > MODE_SQ_OUT) begin
        f = FRAC_ONE;
      end else if (t < win_start) begin
        f = fade_in ? 64'd0 : 64'(FRAC_ONE);
      end else if (t >= win_end) begin
        f = fade_in ? 64'(FRAC_ONE) : 64'd0;
      end else begin
        offs = t - win_start;
        span = win_end - win_start;
        num  = offs;
        num  = num << FRAC_BITS;
        f    = num / span;
        if (!fade_in) f = FRAC_ONE - f;
        if (squared) f = (f * f) >> FRAC_BITS;
      end
      return f[FRAC_W-1:0];
    endfunction

    function logic [CW-1:0] scale_channel(logic [CW-1:0] c, logic [FRAC_W-1:0] f);
      logic [63:0] p;
      p = c;
      p = p * f;
      return p[FRAC_BITS +: CW];
    endfunction

    function void note_pixel(logic [CW-1:0] r, logic [CW-1:0] g, logic [CW-1:0] b,
                             logic [TW-1:0] t);
      logic [FRAC_W-1:0] f;
      rgb_word_t         want;
      f          = fade_fraction(t);
      want.red   = scale_channel(r, f);
      want.green = scale_channel(g, f);
      want.blue  = scale_channel(b, f);
      expected_rgb = {expected_rgb, want};
    endfunction

    function void check_pixel(rgb_word_t got);
      rgb_word_t want;
      results_seen++;
      if (expected_rgb.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: output word %0d with nothing pending: r=%h g=%h b=%h",
                   results_seen, got.red, got.green, got.blue);
        return;
      end
      want = expected_rgb.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: output word %0d expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                   results_seen, want.red, want.green, want.blue,
                   got.red, got.green, got.blue);
      end
    endfunction

    function int unsigned pending();
      return expected_rgb.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TW-1:0]        cfg_wdata;

  tcf_pix_if #(.CW(CW), .TW(TW)) pix_if ();
  tcf_rgb_if #(.CW(CW))          rgb_if ();

  timed_color_fade #(
    .CHANNEL_BITS (CW),
    .TIME_BITS    (TW)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_if),
    .out_rgb   (rgb_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fade_scoreboard sb;

  // Shared controls: no_gaps drops idling on both sides, hold_output asks the
  // receiver for one long stall.
  bit          no_gaps;
  bit          hold_output;
  int unsigned pixels_in;
  int unsigned cfg_writes;
  int unsigned settings_run;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Monitor: note accepted pixel words first, then check the faded word that
  // leaves at the same edge (it always belongs to an older pixel).
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (pix_if.valid && pix_if.ready) begin
        sb.note_pixel(pix_if.red_in, pix_if.green_in, pix_if.blue_in, pix_if.now_ms);
        pixels_in++;
      end
      if (rgb_if.valid && rgb_if.ready)
        sb.check_pixel(rgb_word_t'{rgb_if.red_out, rgb_if.green_out, rgb_if.blue_out});
    end
  end

  // Watchdog: give up after a long run of cycles with no word moving and no
  // register written.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((pix_if.valid && pix_if.ready) || (rgb_if.valid && rgb_if.ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
    $display("timed_color_fade verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: per word, hold ready low for a random gap, then raise it and
  // wait for the word. On request, stall for HOLD_CYCLES so the pipe fills
  // and pushes back on the input.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    rgb_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_output) begin
        hold_output = 1'b0;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          rgb_if.ready <= 1'b0;
        end
      end
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
        @(negedge clk);
        rgb_if.ready <= 1'b0;
      end
      @(negedge clk);
      rgb_if.ready <= 1'b1;
      @(posedge clk);
      while (!rgb_if.valid) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------

  // Offer one pixel word after a random gap and hold it until accepted.
  task automatic push_pixel(logic [CW-1:0] r, logic [CW-1:0] g, logic [CW-1:0] b,
                            logic [TW-1:0] t);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      pix_if.valid <= 1'b0;
    end
    @(negedge clk);
    pix_if.valid    <= 1'b1;
    pix_if.red_in   <= r;
    pix_if.green_in <= g;
    pix_if.blue_in  <= b;
    pix_if.now_ms   <= t;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
  endtask

  // Stop offering, wait for every pending faded word, then let the pipe settle.
  task automatic drain_pipeline();
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
    cfg_writes++;
  endtask

  // Rewrite all three registers while the block is idle.
  task automatic set_config(logic [2:0] mode, logic [TW-1:0] ws, logic [TW-1:0] we,
                            bit poke_unused);
    drain_pipeline();
    write_reg(REG_FADE_MODE, TW'(mode));
    write_reg(REG_WIN_START, ws);
    write_reg(REG_WIN_END, we);
    if (poke_unused) write_reg(REG_UNUSED, $urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Channel value, biased toward the two extremes.
  function automatic logic [CW-1:0] pick_channel();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return CW'($urandom_range(0, (1 << CW) - 1));
  endfunction

  // Timestamp: mostly inside the window, some on its edges, some anywhere.
  function automatic logic [TW-1:0] pick_time(logic [TW-1:0] ws, logic [TW-1:0] we);
    logic [TW-1:0] span;
    int unsigned   roll;
    span = we - ws;
    roll = $urandom_range(0, 99);
    if (roll < 15) return $urandom;
    if (roll < 35) begin
      case ($urandom_range(0, 5))
        0:       return ws - 1;
        1:       return ws;
        2:       return we - 1;
        3:       return we;
        4:       return we + 1;
        default: return ws + 1;
      endcase
    end
    if (we > ws) return ws + ($urandom % span);
    // Empty or inverted window: land around both ends.
    if ($urandom_range(0, 1) != 0) return ws + $urandom_range(0, 4000) - 2000;
    return we + $urandom_range(0, 4000) - 2000;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [2:0]    mode;
    logic [TW-1:0] ws;
    logic [TW-1:0] we;
    sb           = new();
    no_gaps      = 1'b0;
    hold_output  = 1'b0;
    pixels_in    = 0;
    cfg_writes   = 0;
    settings_run = 0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_FADE_MODE;
    cfg_wdata       = '0;
    pix_if.valid    = 1'b0;
    pix_if.red_in   = '0;
    pix_if.green_in = '0;
    pix_if.blue_in  = '0;
    pix_if.now_ms   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset registers: mode none and an empty window pass pixels through.
    push_pixel('0, '0, '0, '0);
    push_pixel('1, '1, '1, '1);
    push_pixel(16'h1234, 16'h8000, 16'hFFFF, 32'd5);

    // Fade in over [100, 1100): black before, ramp inside, pass after.
    set_config(MODE_IN, 32'd100, 32'd1100, 1'b0);
    push_pixel('1, '1, '1, 32'd0);
    push_pixel('1, 16'h8001, 16'h0001, 32'd99);
    push_pixel('1, '1, '1, 32'd100);
    push_pixel('1, 16'h7FFF, 16'h0100, 32'd600);
    push_pixel('1, '1, '1, 32'd1099);
    push_pixel('1, 16'hABCD, 16'h0001, 32'd1100);
    push_pixel('1, '1, '1, '1);

    // Fade out: pass before, full fraction at the start edge, black at end.
    set_config(MODE_OUT, 32'd100, 32'd1100, 1'b0);
    push_pixel(16'h5555, 16'hAAAA, '1, 32'd99);
    push_pixel('1, '1, '1, 32'd100);
    push_pixel('1, 16'h8000, 16'h0002, 32'd1099);
    push_pixel('1, '1, '1, 32'd1100);

    // Squared shapes; squared fade out at the start edge keeps 1.0.
    set_config(MODE_SQ_IN, 32'd100, 32'd1100, 1'b0);
    push_pixel('1, 16'h8000, 16'h4000, 32'd600);
    push_pixel('1, '1, '1, 32'd1099);
    set_config(MODE_SQ_OUT, 32'd100, 32'd1100, 1'b0);
    push_pixel('1, '1, '1, 32'd100);
    push_pixel('1, 16'h8000, 16'h4000, 32'd600);

    // Inverted window: never entered, only the before and after rules apply.
    set_config(MODE_IN, 32'd5000, 32'd1000, 1'b0);
    push_pixel('1, '1, '1, 32'd500);
    push_pixel('1, '1, '1, 32'd3000);
    push_pixel('1, '1, '1, 32'd6000);

    // Widest window, then an unused mode code with a live window.
    set_config(MODE_IN, '0, '1, 1'b1);
    push_pixel('1, '1, '1, 32'hFFFF_FFFE);
    push_pixel('1, '1, '1, '0);
    set_config(3'd7, 32'd100, 32'd1100, 1'b0);
    push_pixel(16'h1357, 16'h2468, '1, 32'd600);

    // Random phases: new mode and window each time, pixels mostly in window.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 11))
        0, 4:    mode = MODE_IN;
        1, 5:    mode = MODE_OUT;
        2, 6:    mode = MODE_SQ_IN;
        3, 7:    mode = MODE_SQ_OUT;
        8:       mode = MODE_NONE;
        9:       mode = 3'd5;
        10:      mode = 3'd6;
        default: mode = 3'd7;
      endcase
      ws = $urandom;
      case (phase == 0 ? 3 : $urandom_range(0, 5))
        0:       we = ws + $urandom_range(1, 64);
        1:       we = ws + $urandom_range(1, 100000);
        2:       we = $urandom;
        3: begin
          ws = '0;
          we = '1;
        end
        4:       we = ws - $urandom_range(0, 1000);
        default: begin
          ws = '1 - $urandom_range(1, 5000);
          we = '1;
        end
      endcase
      set_config(mode, ws, we, $urandom_range(0, 3) == 0);

      // Run every fourth phase flat out; ask for long output stalls twice.
      no_gaps = (phase % 4 == 3);
      if (phase == 2 || phase == 11) hold_output = 1'b1;

      for (int i = 0; i < PHASE_ITEMS; i++)
        push_pixel(pick_channel(), pick_channel(), pick_channel(), pick_time(ws, we));
      no_gaps = 1'b0;
    end

    drain_pipeline();

    $display("Summary: %0d pixel words checked across %0d register settings, %0d writes",
             sb.results_seen, settings_run, cfg_writes);
    $display("Summary: modes none through squared out plus unused codes, %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("timed_color_fade verification clean");
    end else begin
      if (sb.pending() != 0)
        $display("ERROR: %0d faded words never arrived", sb.pending());
      $display("timed_color_fade verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tcf_pkg.sv
rtl/core/tcf_if.sv
rtl/core/tcf_window.sv
rtl/core/tcf_div_step.sv
rtl/core/tcf_shape.sv
rtl/core/tcf_scale.sv
rtl/core/timed_color_fade.sv
test/timed_color_fade_test.sv
